[src/rrp_pkg.sv]
// Package with shared types and constants for the request parser.
package rrp_pkg;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_ARG_END = 2'd1;
    localparam logic [1:0] KIND_CMD_END = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [1:0] ERR_COUNT  = 2'd0;
    localparam logic [1:0] ERR_DOLLAR = 2'd1;
    localparam logic [1:0] ERR_BLEN   = 2'd2;
    localparam logic [1:0] ERR_CRLF   = 2'd3;

    localparam int unsigned CNT_W = 17;
    localparam int unsigned LEN_W = 21;
    localparam logic [CNT_W-1:0] CNT_SAT = 17'd65536;
    localparam logic [CNT_W-1:0] CNT_RST = 17'd65536;
    localparam logic [LEN_W-1:0] LEN_RST = 21'd1048576;

    localparam logic [2:0] MAX_RES = 3'd4;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [CNT_W-1:0] total;
        logic [1:0]       err;
        logic             last;
    } t_result;

    typedef struct packed {
        logic [2:0] count;
        t_result    r0;
        t_result    r1;
        t_result    r2;
        t_result    r3;
    } t_group;

    function automatic t_result mk_res(logic [1:0] kind, logic [7:0] data,
                                       logic [CNT_W-1:0] total, logic [1:0] err);
        t_result r;
        r.kind  = kind;
        r.data  = data;
        r.total = total;
        r.err   = err;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
        end
        return t[3:0];
    endfunction

    function automatic logic [7:0] esc_map(logic [7:0] c);
        logic [7:0] t;
        unique case (c)
            8'h6e: t = 8'h0a;
            8'h72: t = 8'h0d;
            8'h74: t = 8'h09;
            8'h62: t = 8'h08;
            8'h61: t = 8'h07;
            default: t = c;
        endcase
        return t;
    endfunction

endpackage

[src/rrp_byte_if.sv]
// Handshake channel interfaces for request bytes and parse results.
interface rrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface rrp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [16:0] arg_total;
    logic [1:0]  error_code;
    logic        last_of_run;
    modport source (output valid, output out_kind, output out_byte, output arg_total,
                    output error_code, output last_of_run, input ready);
    modport sink (input valid, input out_kind, input out_byte, input arg_total,
                  input error_code, input last_of_run, output ready);
endinterface

[src/rrp_front.sv]
// Front end: parses one byte per cycle, when i_fire is high, into a group of up to four results.
module rrp_front
    import rrp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    input  logic [CNT_W-1:0] i_max_args,
    input  logic [LEN_W-1:0] i_max_len,
    output t_group           o_group
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_CNT     = 4'd1;
    localparam logic [3:0] PH_CNT_LF  = 4'd2;
    localparam logic [3:0] PH_DOLLAR  = 4'd3;
    localparam logic [3:0] PH_BLEN    = 4'd4;
    localparam logic [3:0] PH_BLEN_LF = 4'd5;
    localparam logic [3:0] PH_DATA    = 4'd6;
    localparam logic [3:0] PH_DATA_CR = 4'd7;
    localparam logic [3:0] PH_DATA_LF = 4'd8;
    localparam logic [3:0] PH_GAP     = 4'd9;
    localparam logic [3:0] PH_BARE    = 4'd10;
    localparam logic [3:0] PH_DQ      = 4'd11;
    localparam logic [3:0] PH_SQ      = 4'd12;

    localparam logic [7:0] CH_STAR = 8'h2a;
    localparam logic [7:0] CH_DOL  = 8'h24;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_SQ   = 8'h27;
    localparam logic [7:0] CH_BS   = 8'h5c;
    localparam logic [7:0] CH_X    = 8'h78;

    logic [3:0]       r_phase, n_phase;
    logic [CNT_W-1:0] r_expect, n_expect;
    logic [CNT_W-1:0] r_done, n_done;
    logic [LEN_W-1:0] r_acc, n_acc;
    logic [LEN_W-1:0] r_left, n_left;
    logic [7:0]       r_hex, n_hex;
    logic [1:0]       r_held, n_held;
    logic             r_closed, n_closed;
    logic             r_crp, n_crp;
    logic             r_dseen, n_dseen;

    t_result    res [4];
    logic [2:0] cnt;
    logic       dig;
    logic [LEN_W+3:0] v;

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] x);
        return (x < CNT_SAT) ? x + 1'b1 : x;
    endfunction

    always_comb begin
        logic [7:0] b;
        logic [7:0] c;
        logic       again;
        logic       go;
        b        = i_byte;
        dig      = (b >= 8'h30 && b <= 8'h39);
        v        = {4'b0000, r_acc} * 25'd10 + {17'd0, b - 8'h30};
        n_phase  = r_phase;
        n_expect = r_expect;
        n_done   = r_done;
        n_acc    = r_acc;
        n_left   = r_left;
        n_hex    = r_hex;
        n_held   = r_held;
        n_closed = r_closed;
        n_crp    = r_crp;
        n_dseen  = r_dseen;
        cnt      = 3'd0;
        for (int k = 0; k < 4; k++) begin
            res[k] = mk_res(KIND_BYTE, 8'h00, '0, 2'd0);
        end
        c     = b;
        go    = 1'b0;
        again = 1'b0;
        if (!r_closed) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (b == CH_STAR) begin
                        n_phase = PH_CNT;
                        n_acc   = '0;
                    end else begin
                        n_phase = PH_GAP;
                        n_done  = '0;
                        n_held  = 2'd0;
                        n_crp   = 1'b0;
                        go      = 1'b1;
                    end
                end
                PH_CNT: begin
                    if (dig) begin
                        if (v > {8'd0, i_max_args}) begin
                            res[0] = mk_res(KIND_ERROR, 8'h00, '0, ERR_COUNT);
                            cnt = 3'd1; n_closed = 1'b1;
                        end else begin
                            n_acc = v[LEN_W-1:0];
                        end
                    end else if (b == CH_CR) begin
                        n_phase = PH_CNT_LF;
                    end else begin
                        res[0] = mk_res(KIND_ERROR, 8'h00, '0, ERR_COUNT);
                        cnt = 3'd1; n_closed = 1'b1;
                    end
                end
                PH_CNT_LF: begin
                    if (b == CH_LF && r_acc != '0) begin
                        n_expect = r_acc[CNT_W-1:0];
                        n_done   = '0;
                        n_phase  = PH_DOLLAR;
                    end else begin
                        res[0] = mk_res(KIND_ERROR, 8'h00, '0, ERR_COUNT);
                        cnt = 3'd1; n_closed = 1'b1;
                    end
                end
                PH_DOLLAR: begin
                    if (b == CH_DOL) begin
                        n_phase = PH_BLEN; n_acc = '0; n_dseen = 1'b0;
                    end else begin
                        res[0] = mk_res(KIND_ERROR, 8'h00, '0, ERR_DOLLAR);
                        cnt = 3'd1; n_closed = 1'b1;
                    end
                end
                PH_BLEN: begin
                    if (dig) begin
                        if (v > {4'd0, i_max_len}) begin
                            res[0] = mk_res(KIND_ERROR, 8'h00, '0, ERR_BLEN);
                            cnt = 3'd1; n_closed = 1'b1;
                        end else begin
                            n_acc = v[LEN_W-1:0]; n_dseen = 1'b1;
                        end
                    end else if (b == CH_CR) begin
                        n_phase = PH_BLEN_LF;
                    end else begin
                        res[0] = mk_res(KIND_ERROR, 8'h00, '0, ERR_BLEN);
                        cnt = 3'd1; n_closed = 1'b1;
                    end
                end
                PH_BLEN_LF: begin
                    if (b == CH_LF && r_dseen) begin
                        n_left  = r_acc;
                        n_phase = (r_acc != '0) ? PH_DATA : PH_DATA_CR;
                    end else begin
                        res[0] = mk_res(KIND_ERROR, 8'h00, '0, ERR_BLEN);
                        cnt = 3'd1; n_closed = 1'b1;
                    end
                end
                PH_DATA: begin
                    res[0] = mk_res(KIND_BYTE, b, '0, 2'd0);
                    cnt = 3'd1;
                    if (r_left <= 21'd1) begin
                        n_left = '0; n_phase = PH_DATA_CR;
                    end else begin
                        n_left = r_left - 1'b1;
                    end
                end
                PH_DATA_CR: begin
                    if (b == CH_CR) begin
                        n_phase = PH_DATA_LF;
                    end else begin
                        res[0] = mk_res(KIND_ERROR, 8'h00, '0, ERR_CRLF);
                        cnt = 3'd1; n_closed = 1'b1;
                    end
                end
                PH_DATA_LF: begin
                    if (b != CH_LF) begin
                        res[0] = mk_res(KIND_ERROR, 8'h00, '0, ERR_CRLF);
                        cnt = 3'd1; n_closed = 1'b1;
                    end else begin
                        res[0] = mk_res(KIND_ARG_END, 8'h00, '0, 2'd0);
                        cnt = 3'd1;
                        n_done = r_done + 1'b1;
                        if (r_done + 1'b1 >= r_expect) begin
                            res[1] = mk_res(KIND_CMD_END, 8'h00, r_expect, 2'd0);
                            cnt = 3'd2; n_done = '0; n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_DOLLAR;
                        end
                    end
                end
                PH_GAP, PH_BARE, PH_DQ, PH_SQ: go = 1'b1;
                default: n_phase = PH_IDLE;
            endcase
        end
        if (go) begin
            // Inline path: resolve a pending CR first, then feed the byte.
            // The second pass feeds the current byte unless the first pass ended the line.
            for (int pass = 0; pass < 2; pass++) begin
                logic       do_feed;
                do_feed = 1'b0;
                if (pass == 0) begin
                    if (n_crp) begin
                        n_crp = 1'b0;
                        if (b == CH_LF) begin
                            if (n_held == 2'd1) begin
                                res[cnt[1:0]] = mk_res(KIND_BYTE, CH_BS, '0, 2'd0);
                                cnt = cnt + 1'b1;
                            end else if (n_held != 2'd0) begin
                                res[cnt[1:0]] = mk_res(KIND_BYTE, CH_X, '0, 2'd0);
                                cnt = cnt + 1'b1;
                                if (n_held == 2'd3) begin
                                    res[cnt[1:0]] = mk_res(KIND_BYTE, n_hex, '0, 2'd0);
                                    cnt = cnt + 1'b1;
                                end
                            end
                            n_held = 2'd0;
                            if (n_phase == PH_BARE || n_phase == PH_DQ || n_phase == PH_SQ) begin
                                res[cnt[1:0]] = mk_res(KIND_ARG_END, 8'h00, '0, 2'd0);
                                cnt = cnt + 1'b1;
                                n_done = sat_inc(n_done);
                            end
                            if (n_done != '0) begin
                                res[cnt[1:0]] = mk_res(KIND_CMD_END, 8'h00, n_done, 2'd0);
                                cnt = cnt + 1'b1;
                            end
                            n_done  = '0;
                            n_phase = PH_IDLE;
                        end else begin
                            c = CH_CR; do_feed = 1'b1;
                        end
                    end
                end else begin
                    if (!(n_phase == PH_IDLE && r_phase != PH_IDLE) || r_phase == PH_IDLE) begin
                        if (!(pass == 1 && n_phase == PH_IDLE && r_phase != PH_IDLE)) begin
                            if (b == CH_CR) begin
                                n_crp = 1'b1;
                            end else begin
                                c = b; do_feed = 1'b1;
                            end
                        end
                    end
                end
                if (do_feed) begin
                    // Feed with up to one reparse of the current byte.
                    again = 1'b1;
                    for (int f = 0; f < 2; f++) begin
                        if (again) begin
                            again = 1'b0;
                            unique case (n_phase)
                                PH_GAP: begin
                                    if (c != CH_SP) begin
                                        n_held = 2'd0;
                                        if (c == CH_DQ) n_phase = PH_DQ;
                                        else if (c == CH_SQ) n_phase = PH_SQ;
                                        else begin
                                            n_phase = PH_BARE;
                                            res[cnt[1:0]] = mk_res(KIND_BYTE, c, '0, 2'd0);
                                            cnt = cnt + 1'b1;
                                        end
                                    end
                                end
                                PH_BARE: begin
                                    if (c == CH_SP) begin
                                        res[cnt[1:0]] = mk_res(KIND_ARG_END, 8'h00, '0, 2'd0);
                                        cnt = cnt + 1'b1;
                                        n_done = sat_inc(n_done); n_phase = PH_GAP;
                                    end else begin
                                        res[cnt[1:0]] = mk_res(KIND_BYTE, c, '0, 2'd0);
                                        cnt = cnt + 1'b1;
                                    end
                                end
                                PH_DQ: begin
                                    unique case (n_held)
                                        2'd0: begin
                                            if (c == CH_BS) n_held = 2'd1;
                                            else if (c == CH_DQ) begin
                                                res[cnt[1:0]] = mk_res(KIND_ARG_END, 8'h00, '0,
                                                                       2'd0);
                                                cnt = cnt + 1'b1;
                                                n_done = sat_inc(n_done); n_phase = PH_GAP;
                                            end else begin
                                                res[cnt[1:0]] = mk_res(KIND_BYTE, c, '0, 2'd0);
                                                cnt = cnt + 1'b1;
                                            end
                                        end
                                        2'd1: begin
                                            if (c == CH_X) n_held = 2'd2;
                                            else begin
                                                res[cnt[1:0]] = mk_res(KIND_BYTE, esc_map(c),
                                                                       '0, 2'd0);
                                                cnt = cnt + 1'b1;
                                                n_held = 2'd0;
                                            end
                                        end
                                        2'd2: begin
                                            if (is_hex(c)) begin
                                                n_hex = c; n_held = 2'd3;
                                            end else begin
                                                res[cnt[1:0]] = mk_res(KIND_BYTE, CH_X, '0, 2'd0);
                                                cnt = cnt + 1'b1;
                                                n_held = 2'd0; again = 1'b1;
                                            end
                                        end
                                        default: begin
                                            n_held = 2'd0;
                                            if (is_hex(c)) begin
                                                res[cnt[1:0]] = mk_res(KIND_BYTE,
                                                    {hex_val(n_hex), hex_val(c)}, '0, 2'd0);
                                                cnt = cnt + 1'b1;
                                            end else begin
                                                res[cnt[1:0]] = mk_res(KIND_BYTE, CH_X, '0, 2'd0);
                                                cnt = cnt + 1'b1;
                                                res[cnt[1:0]] = mk_res(KIND_BYTE, n_hex, '0, 2'd0);
                                                cnt = cnt + 1'b1;
                                                again = 1'b1;
                                            end
                                        end
                                    endcase
                                end
                                PH_SQ: begin
                                    if (n_held == 2'd0) begin
                                        if (c == CH_BS) n_held = 2'd1;
                                        else if (c == CH_SQ) begin
                                            res[cnt[1:0]] = mk_res(KIND_ARG_END, 8'h00, '0, 2'd0);
                                            cnt = cnt + 1'b1;
                                            n_done = sat_inc(n_done); n_phase = PH_GAP;
                                        end else begin
                                            res[cnt[1:0]] = mk_res(KIND_BYTE, c, '0, 2'd0);
                                            cnt = cnt + 1'b1;
                                        end
                                    end else begin
                                        n_held = 2'd0;
                                        if (c == CH_SQ) begin
                                            res[cnt[1:0]] = mk_res(KIND_BYTE, CH_SQ, '0, 2'd0);
                                            cnt = cnt + 1'b1;
                                        end else begin
                                            res[cnt[1:0]] = mk_res(KIND_BYTE, CH_BS, '0, 2'd0);
                                            cnt = cnt + 1'b1;
                                            again = 1'b1;
                                        end
                                    end
                                end
                                default: n_phase = PH_GAP;
                            endcase
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        o_group.count = cnt;
        o_group.r0 = res[0];
        o_group.r1 = res[1];
        o_group.r2 = res[2];
        o_group.r3 = res[3];
        unique case (cnt)
            3'd1: o_group.r0.last = 1'b1;
            3'd2: o_group.r1.last = 1'b1;
            3'd3: o_group.r2.last = 1'b1;
            3'd4: o_group.r3.last = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_expect <= '0;
            r_done   <= '0;
            r_acc    <= '0;
            r_left   <= '0;
            r_hex    <= '0;
            r_held   <= '0;
            r_closed <= 1'b0;
            r_crp    <= 1'b0;
            r_dseen  <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_expect <= n_expect;
            r_done   <= n_done;
            r_acc    <= n_acc;
            r_left   <= n_left;
            r_hex    <= n_hex;
            r_held   <= n_held;
            r_closed <= n_closed;
            r_crp    <= n_crp;
            r_dseen  <= n_dseen;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt <= MAX_RES) else $error("too many results for one beat");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_closed |-> cnt == 3'd0) else $error("result after a protocol error");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && n_closed && !r_closed |=> r_closed) else $error("error did not close");

endmodule

[src/rrp_back.sv]
// Back end: result group queue that serializes each group onto the output.
module rrp_back
    import rrp_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_group        i_group,
    output logic          o_space,
    rrp_res_if.source     res
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_group            r_mem [DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [AW:0]       r_fill;
    logic [1:0]        r_idx;
    t_group            head;
    t_result           cur;
    logic              pop_res;
    logic              pop_grp;
    logic              push;

    assign head    = r_mem[r_rp];
    assign push    = i_push && i_group.count != 3'd0;
    assign o_space = r_fill < (AW+1)'(DEPTH);

    always_comb begin
        unique case (r_idx)
            2'd0: cur = head.r0;
            2'd1: cur = head.r1;
            2'd2: cur = head.r2;
            default: cur = head.r3;
        endcase
    end

    assign res.valid       = r_fill != '0;
    assign res.out_kind    = cur.kind;
    assign res.out_byte    = cur.data;
    assign res.arg_total   = cur.total;
    assign res.error_code  = cur.err;
    assign res.last_of_run = cur.last;
    assign pop_res = res.valid && res.ready;
    assign pop_grp = pop_res && cur.last;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
            r_idx  <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop_grp) begin
                r_rp  <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
                r_idx <= '0;
            end else if (pop_res) begin
                r_idx <= r_idx + 1'b1;
            end
            r_fill <= r_fill + (AW+1)'(push) - (AW+1)'(pop_grp);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (AW+1)'(DEPTH)) else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> {1'b0, r_idx} < head.count) else $error("index past group");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill == '0 |-> r_idx == '0) else $error("index left over");

endmodule

[src/resp_request_parser.sv]
// Top level of the request parser: config registers, front parser and result queue.
//   channel | dir | beat
//   req     | in  | one request byte
//   rsp     | out | one result (kind, byte, count, error, last flag)
//   apb     | in  | configuration register writes and reads
// The parser takes one byte every cycle while the result queue has room.
// Each byte yields zero to four results; results leave one per cycle while rsp is ready.
// Sustained rate is one byte per cycle as long as results average one per byte and rsp stays ready.
// Reset is synchronous and active low; registers return to their defaults.
// A stalled result side fills the queue of QUEUE_DEPTH groups and then stops input.
module resp_request_parser
    import rrp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrp_byte_if.sink    req,
    rrp_res_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ADDR_MAX_ARGS = 3'd0;
    localparam logic [2:0] ADDR_MAX_LEN  = 3'd4;

    logic [CNT_W-1:0] r_max_args;
    logic [LEN_W-1:0] r_max_len;
    logic             fire;
    logic             space;
    t_group           grp;

    assign pready = 1'b1;
    always_comb begin
        unique case (paddr)
            ADDR_MAX_ARGS: prdata = {15'd0, r_max_args};
            ADDR_MAX_LEN:  prdata = {11'd0, r_max_len};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_args <= CNT_RST;
            r_max_len  <= LEN_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr == ADDR_MAX_ARGS) r_max_args <= pwdata[CNT_W-1:0];
            if (paddr == ADDR_MAX_LEN)  r_max_len  <= pwdata[LEN_W-1:0];
        end
    end

    assign req.ready = space;
    assign fire      = req.valid && space;

    rrp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_byte     (req.in_byte),
        .i_max_args (r_max_args),
        .i_max_len  (r_max_len),
        .o_group    (grp)
    );

    rrp_back #(.DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_group (grp),
        .o_space (space),
        .res     (rsp)
    );

endmodule

[sim/resp_request_parser_test.sv]
// Self-checking testbench for the request parser with a built-in protocol predictor.
module resp_request_parser_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rrp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_STAR = 8'h2a;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DQ = 8'h22;
    localparam logic [7:0] CH_SQ = 8'h27;
    localparam logic [7:0] CH_BSL = 8'h5c;
    localparam logic [7:0] CH_X = 8'h78;
    localparam logic [2:0] ADDR_MAX_CNT = 3'd0;
    localparam logic [2:0] ADDR_MAX_LEN = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_CNT, S_CNT_LF, S_DOLLAR, S_BLEN, S_BLEN_LF, S_DATA,
        S_DATA_CR, S_DATA_LF, S_GAP, S_BARE, S_DQ, S_SQ
    } t_phase;

    typedef struct {
        logic [7:0] b;
        bit         typed;
        t_result    r;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    rrp_byte_if req_ch ();
    rrp_res_if  rsp_ch ();

    resp_request_parser u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req_ch), .rsp(rsp_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Parser state mirrored by the predictor.
    logic [16:0] lim_count;
    logic [20:0] lim_length;
    t_phase      phase;
    int unsigned want_args, seen_args, accum, remaining;
    logic [7:0]  esc_hold [3];
    int unsigned esc_n;
    bit          halted, cr_wait, have_digit;
    t_result     byte_results[$];

    t_result     pending_results[$];
    t_row        typed_rows[$];
    t_row        dir_rows[$];
    logic [7:0]  stim[$];
    int unsigned errors;
    int unsigned cycles;
    int unsigned hold_cnt;
    bit          no_gaps;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic void put_result(logic [1:0] k, logic [7:0] d, logic [16:0] t,
                                       logic [1:0] e);
        t_result r;
        if (byte_results.size() >= 4) return;
        r.kind = k;
        r.data = d;
        r.total = t;
        r.err = e;
        r.last = 1'b0;
        byte_results.insert(byte_results.size(), r);
    endfunction

    function automatic void halt_with(logic [1:0] e);
        put_result(KIND_ERROR, 8'h00, '0, e);
        halted = 1'b1;
    endfunction

    function automatic void close_token();
        put_result(KIND_ARG_END, 8'h00, '0, 2'd0);
        if (seen_args < 65536) seen_args++;
        phase = S_GAP;
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic logic [7:0] unescape(logic [7:0] c);
        case (c)
            "n": return CH_LF;
            "r": return CH_CR;
            "t": return 8'h09;
            "b": return 8'h08;
            "a": return 8'h07;
            default: return c;
        endcase
    endfunction

    function automatic void token_byte(logic [7:0] c);
        int hi, lo;
        case (phase)
            S_GAP: begin
                if (c == CH_SP) return;
                esc_n = 0;
                if (c == CH_DQ) phase = S_DQ;
                else if (c == CH_SQ) phase = S_SQ;
                else begin
                    phase = S_BARE;
                    put_result(KIND_BYTE, c, '0, 2'd0);
                end
            end
            S_BARE: begin
                if (c == CH_SP) close_token();
                else put_result(KIND_BYTE, c, '0, 2'd0);
            end
            S_DQ: begin
                if (esc_n == 0) begin
                    if (c == CH_BSL) begin
                        esc_hold[0] = c;
                        esc_n = 1;
                    end else if (c == CH_DQ) close_token();
                    else put_result(KIND_BYTE, c, '0, 2'd0);
                end else if (esc_n == 1) begin
                    if (c == CH_X) begin
                        esc_hold[1] = c;
                        esc_n = 2;
                    end else begin
                        put_result(KIND_BYTE, unescape(c), '0, 2'd0);
                        esc_n = 0;
                    end
                end else if (esc_n == 2) begin
                    if (hex_digit(c) >= 0) begin
                        esc_hold[2] = c;
                        esc_n = 3;
                    end else begin
                        put_result(KIND_BYTE, CH_X, '0, 2'd0);
                        esc_n = 0;
                        token_byte(c);
                    end
                end else begin
                    hi = hex_digit(esc_hold[2]);
                    lo = hex_digit(c);
                    esc_n = 0;
                    if (lo >= 0 && hi >= 0) put_result(KIND_BYTE, 8'(hi * 16 + lo), '0, 2'd0);
                    else begin
                        put_result(KIND_BYTE, CH_X, '0, 2'd0);
                        put_result(KIND_BYTE, esc_hold[2], '0, 2'd0);
                        token_byte(c);
                    end
                end
            end
            S_SQ: begin
                if (esc_n == 0) begin
                    if (c == CH_BSL) begin
                        esc_hold[0] = c;
                        esc_n = 1;
                    end else if (c == CH_SQ) close_token();
                    else put_result(KIND_BYTE, c, '0, 2'd0);
                end else begin
                    esc_n = 0;
                    if (c == CH_SQ) put_result(KIND_BYTE, CH_SQ, '0, 2'd0);
                    else begin
                        put_result(KIND_BYTE, CH_BSL, '0, 2'd0);
                        token_byte(c);
                    end
                end
            end
            default: phase = S_GAP;
        endcase
    endfunction

    function automatic void finish_line();
        if (esc_n != 0) begin
            if (esc_n == 1) put_result(KIND_BYTE, CH_BSL, '0, 2'd0);
            else begin
                put_result(KIND_BYTE, CH_X, '0, 2'd0);
                if (esc_n == 3) put_result(KIND_BYTE, esc_hold[2], '0, 2'd0);
            end
            esc_n = 0;
        end
        if (phase == S_BARE || phase == S_DQ || phase == S_SQ) close_token();
        if (seen_args > 0) put_result(KIND_CMD_END, 8'h00, 17'(seen_args), 2'd0);
        seen_args = 0;
        phase = S_IDLE;
    endfunction

    function automatic void inline_in(logic [7:0] b);
        if (cr_wait) begin
            cr_wait = 1'b0;
            if (b == CH_LF) begin
                finish_line();
                return;
            end
            token_byte(CH_CR);
        end
        if (b == CH_CR) cr_wait = 1'b1;
        else token_byte(b);
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        bit          dig;
        int unsigned v;
        dig = (b >= "0" && b <= "9");
        v = accum * 10 + (int'(b) - int'("0"));
        byte_results.delete();
        if (halted) return;
        case (phase)
            S_IDLE: begin
                if (b == CH_STAR) begin
                    phase = S_CNT;
                    accum = 0;
                end else begin
                    phase = S_GAP;
                    seen_args = 0;
                    esc_n = 0;
                    cr_wait = 1'b0;
                    inline_in(b);
                end
            end
            S_CNT: begin
                if (dig) begin
                    if (v > lim_count) halt_with(ERR_COUNT);
                    else accum = v;
                end else if (b == CH_CR) phase = S_CNT_LF;
                else halt_with(ERR_COUNT);
            end
            S_CNT_LF: begin
                if (b == CH_LF && accum != 0) begin
                    want_args = accum;
                    seen_args = 0;
                    phase = S_DOLLAR;
                end else halt_with(ERR_COUNT);
            end
            S_DOLLAR: begin
                if (b == CH_DOLLAR) begin
                    phase = S_BLEN;
                    accum = 0;
                    have_digit = 1'b0;
                end else halt_with(ERR_DOLLAR);
            end
            S_BLEN: begin
                if (dig) begin
                    if (v > lim_length) halt_with(ERR_BLEN);
                    else begin
                        accum = v;
                        have_digit = 1'b1;
                    end
                end else if (b == CH_CR) phase = S_BLEN_LF;
                else halt_with(ERR_BLEN);
            end
            S_BLEN_LF: begin
                if (b == CH_LF && have_digit) begin
                    remaining = accum;
                    phase = (remaining != 0) ? S_DATA : S_DATA_CR;
                end else halt_with(ERR_BLEN);
            end
            S_DATA: begin
                put_result(KIND_BYTE, b, '0, 2'd0);
                if (remaining > 0) remaining--;
                if (remaining == 0) phase = S_DATA_CR;
            end
            S_DATA_CR: begin
                if (b == CH_CR) phase = S_DATA_LF;
                else halt_with(ERR_CRLF);
            end
            S_DATA_LF: begin
                if (b != CH_LF) halt_with(ERR_CRLF);
                else begin
                    put_result(KIND_ARG_END, 8'h00, '0, 2'd0);
                    seen_args = (seen_args + 1) & 32'h1ffff;
                    if (seen_args >= want_args) begin
                        put_result(KIND_CMD_END, 8'h00, 17'(want_args), 2'd0);
                        seen_args = 0;
                        phase = S_IDLE;
                    end else phase = S_DOLLAR;
                end
            end
            S_GAP, S_BARE, S_DQ, S_SQ: inline_in(b);
            default: phase = S_IDLE;
        endcase
        if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
    endfunction

    // Beat monitors: predict on every accepted byte, check every accepted result.
    always @(posedge i_clk) begin
        t_row    row;
        t_result got, want;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            row = typed_rows.pop_front();
            parse_byte(req_ch.in_byte);
            if (row.typed) pending_results.insert(pending_results.size(), row.r);
            else foreach (byte_results[i])
                pending_results.insert(pending_results.size(), byte_results[i]);
        end
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.kind = rsp_ch.out_kind;
            got.data = rsp_ch.out_byte;
            got.total = rsp_ch.arg_total;
            got.err = rsp_ch.error_code;
            got.last = rsp_ch.last_of_run;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result kind=%0d byte=%h total=%0d err=%0d last=%0d",
                         $realtime, got.kind, got.data, got.total, got.err, got.last);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: expected kind=%0d byte=%h total=%0d err=%0d last=%0d",
                             $realtime, want.kind, want.data, want.total, want.err,
                             want.last);
                    $display("%0t:   actual kind=%0d byte=%h total=%0d err=%0d last=%0d",
                             $realtime, got.kind, got.data, got.total, got.err, got.last);
                end
            end
        end
    end

    // Result side: random hold-off per beat, plus a long hold when requested.
    initial begin
        int unsigned w;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            w = no_gaps ? 0 : $urandom_range(0, 7);
            if (w != 0 || hold_cnt != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (w) @(posedge i_clk);
                while (hold_cnt != 0) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
        end
    end

    task automatic send_byte(logic [7:0] b, bit typed, t_result r);
        int unsigned gap;
        t_row        row;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        row.b = b;
        row.typed = typed;
        row.r = r;
        typed_rows.insert(typed_rows.size(), row);
        req_ch.valid <= 1'b1;
        req_ch.in_byte <= b;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_stim();
        t_result none;
        none = '0;
        while (stim.size() != 0) send_byte(stim.pop_front(), 1'b0, none);
    endtask

    task automatic apb_write(logic [2:0] a, logic [31:0] d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== d) begin
            errors++;
            $display("%0t: register %0d expected %h actual %h", $realtime, a, d, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        if (a == ADDR_MAX_CNT) lim_count = d[16:0];
        else lim_length = d[20:0];
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) stim.insert(stim.size(), s[i]);
    endfunction

    function automatic void add_row(string s);
        t_row row;
        row.typed = 1'b0;
        row.r = '0;
        for (int i = 0; i < s.len(); i++) begin
            row.b = s[i];
            dir_rows.insert(dir_rows.size(), row);
        end
    endfunction

    function automatic void add_typed(logic [7:0] b, logic [1:0] k, logic [7:0] d,
                                      logic [16:0] t, logic [1:0] e);
        t_row row;
        row.b = b;
        row.typed = 1'b1;
        row.r.kind = k;
        row.r.data = d;
        row.r.total = t;
        row.r.err = e;
        row.r.last = 1'b1;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void make_command();
        int unsigned n, len, hi_n, hi_len, tokens, kind;
        string       piece;
        string       dq_bits [10];
        string       sq_bits [4];
        dq_bits = '{"\\x4A", "\\xg", "\\x4z", "\\n", "\\r", "\\t", "\\b", "\\a", "\\q", "k"};
        sq_bits = '{"\\'", "\\z", "m", "\\\\"};
        if ($urandom_range(0, 9) < 6) begin
            hi_n = (lim_count < 4) ? lim_count : 4;
            hi_len = (lim_length < 5) ? lim_length : 5;
            n = $urandom_range(1, hi_n);
            if ($urandom_range(0, 3) == 0) n = hi_n;
            push_text($sformatf("*%0d\r\n", n));
            repeat (n) begin
                len = $urandom_range(0, hi_len);
                if ($urandom_range(0, 3) == 0) push_text($sformatf("$0%0d\r\n", len));
                else push_text($sformatf("$%0d\r\n", len));
                repeat (len) stim.insert(stim.size(), 8'($urandom_range(0, 255)));
                push_text("\r\n");
            end
        end else begin
            tokens = $urandom_range(0, 3);
            if ($urandom_range(0, 2) == 0) push_text(" ");
            for (int t = 0; t < tokens; t++) begin
                if (t != 0) begin
                    push_text(" ");
                    if ($urandom_range(0, 3) == 0) push_text(" ");
                end
                kind = $urandom_range(0, 2);
                if (kind == 0) begin
                    repeat ($urandom_range(1, 4)) begin
                        piece = " ";
                        piece[0] = 8'($urandom_range(33, 126));
                        if (piece[0] == CH_STAR || piece[0] == CH_DQ || piece[0] == CH_SQ)
                            piece = "a";
                        push_text(piece);
                        if ($urandom_range(0, 9) == 0) push_text("\r");
                    end
                end else if (kind == 1) begin
                    push_text("\"");
                    repeat ($urandom_range(0, 4)) push_text(dq_bits[$urandom_range(0, 9)]);
                    if ($urandom_range(0, 5) == 0) push_text("\\x4");
                    else if ($urandom_range(0, 7) != 0) push_text("\"");
                end else begin
                    push_text("'");
                    repeat ($urandom_range(0, 4)) push_text(sq_bits[$urandom_range(0, 3)]);
                    if ($urandom_range(0, 5) == 0) push_text("\\");
                    else if ($urandom_range(0, 7) != 0) push_text("'");
                end
            end
            push_text("\r\n");
        end
    endfunction

    initial begin
        int unsigned sent, quota;
        logic [16:0] cnt_set [5];
        logic [20:0] len_set [5];
        t_row        row;
        cnt_set = '{17'd65536, 17'd1, 17'd2, 17'd4, 17'd65536};
        len_set = '{21'd1048576, 21'd0, 21'd3, 21'd5, 21'd1048576};
        cycles = 0;
        errors = 0;
        hold_cnt = 0;
        no_gaps = 1'b0;
        i_rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.in_byte <= 8'h00;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        lim_count = CNT_RST;
        lim_length = LEN_RST;
        phase = S_IDLE;
        want_args = 0;
        seen_args = 0;
        accum = 0;
        remaining = 0;
        esc_hold = '{8'h00, 8'h00, 8'h00};
        esc_n = 0;
        halted = 1'b0;
        cr_wait = 1'b0;
        have_digit = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row("*2\r\n$1\r\n");
        add_typed(8'hff, KIND_BYTE, 8'hff, '0, 2'd0);
        add_row("\r\n$01\r\n");
        add_typed(8'h00, KIND_BYTE, 8'h00, '0, 2'd0);
        add_row("\r\n*1\r\n$0\r\n\r\n");
        add_row("\r\n  \r\n");
        add_row("ab\rc \"x\\x4g\\x41\\q\\n\" 'i\\'t\\z' \"\\x4\r\n");
        add_row("'\\\r\n\"\\x\r\n");
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_byte(row.b, row.typed, row.r);
        end
        drain();

        sent = 0;
        for (int p = 0; p < 5; p++) begin
            apb_write(ADDR_MAX_CNT, 32'(cnt_set[p]));
            apb_write(ADDR_MAX_LEN, 32'(len_set[p]));
            no_gaps = (p == 1);
            if (p == 2) hold_cnt = 400;
            quota = (p + 1) * 45;
            while (sent < quota) begin
                make_command();
                sent += stim.size();
                send_stim();
            end
            drain();
        end

        case ($urandom_range(0, 3))
            0: push_text($urandom_range(0, 1) ? "*0\r\n" : "*7x");
            1: push_text("*1\r\nX");
            2: push_text("*1\r\n$99999999");
            default: push_text("*1\r\n$1\r\nabX");
        endcase
        repeat (6) stim.insert(stim.size(), 8'($urandom_range(0, 255)));
        send_stim();
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

[filelist.f]
src/rrp_pkg.sv
src/rrp_byte_if.sv
src/rrp_front.sv
src/rrp_back.sv
src/resp_request_parser.sv
sim/resp_request_parser_test.sv
